// ----- hw/rtl/qxm_pkg.sv -----
`default_nettype none

package qxm_pkg;

	localparam int PULSE_W   = 12;
	localparam int GYRO_W    = 16;
	localparam int TRIM_W    = 10;
	localparam int GAIN_W    = 16;
	localparam int MOTOR_W   = 11;
	localparam int FRAC_BITS = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	// Centered axis command with 8 fraction bits.
	localparam int AXIS_W = 26;
	// Throttle term with 8 fraction bits.
	localparam int THR_W  = 22;
	// Motor sum of throttle and three axes.
	localparam int SUM_W  = 28;

	localparam int PULSE_CENTRE = 1500;
	localparam int MOTOR_MIN    = 900;
	localparam int MOTOR_MAX    = 1900;
	localparam int MOTOR_OFFSET = 100;

	localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_TRIM = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROLL_TRIM     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PITCH_TRIM    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_TRIM      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ROLL_GAIN     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_PITCH_GAIN    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_GAIN      = 3'd6;

	typedef struct packed {
		logic        [PULSE_W-1:0] throttle_pulse;
		logic        [PULSE_W-1:0] roll_pulse;
		logic        [PULSE_W-1:0] pitch_pulse;
		logic        [PULSE_W-1:0] yaw_pulse;
		logic signed [GYRO_W-1:0]  gyro_roll;
		logic signed [GYRO_W-1:0]  gyro_pitch;
		logic signed [GYRO_W-1:0]  gyro_yaw;
	} sample_t;

	typedef struct packed {
		logic [MOTOR_W-1:0] motor_front_right;
		logic [MOTOR_W-1:0] motor_back_right;
		logic [MOTOR_W-1:0] motor_back_left;
		logic [MOTOR_W-1:0] motor_front_left;
	} motors_t;

endpackage

`default_nettype wire

// ----- hw/rtl/quad_x_damped_motor_mixer.sv -----
`default_nettype none

// X-frame quadcopter mixer with gyro rate damping. An item is taken at every
// clock edge where start is high; busy is always low, so one item per cycle
// is sustained. The result passes through the input register, the axis
// multiply register and the clamp register, and is shown for exactly one
// cycle with done high; the receiver cannot stall, so it must capture the
// four motor pulses in that cycle. Trims and gains are written through the
// cfg port and should only change while no item is in flight.
module quad_x_damped_motor_mixer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire qxm_pkg::sample_t                   sample,
	output      logic                               done,
	output      qxm_pkg::motors_t                   motors,
	input  wire logic                               cfg_we,
	input  wire logic [qxm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [qxm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int SUM_W   = qxm_pkg::SUM_W;
	localparam int THR_C_W = qxm_pkg::PULSE_W + 2;

	logic signed [qxm_pkg::TRIM_W-1:0] throttle_trim_q;
	logic signed [qxm_pkg::TRIM_W-1:0] roll_trim_q;
	logic signed [qxm_pkg::TRIM_W-1:0] pitch_trim_q;
	logic signed [qxm_pkg::TRIM_W-1:0] yaw_trim_q;
	logic signed [qxm_pkg::GAIN_W-1:0] roll_gain_q;
	logic signed [qxm_pkg::GAIN_W-1:0] pitch_gain_q;
	logic signed [qxm_pkg::GAIN_W-1:0] yaw_gain_q;

	qxm_pkg::sample_t sample_s1;
	logic             valid_s1;

	logic signed [THR_C_W-1:0]        thr_sum;
	logic signed [qxm_pkg::AXIS_W-1:0] roll_axis;
	logic signed [qxm_pkg::AXIS_W-1:0] pitch_axis;
	logic signed [qxm_pkg::AXIS_W-1:0] yaw_axis;

	logic signed [qxm_pkg::THR_W-1:0]  thr_s2;
	logic signed [qxm_pkg::AXIS_W-1:0] roll_s2;
	logic signed [qxm_pkg::AXIS_W-1:0] pitch_s2;
	logic signed [qxm_pkg::AXIS_W-1:0] yaw_s2;
	logic                             valid_s2;

	logic signed [SUM_W-1:0] t_w;
	logic signed [SUM_W-1:0] r_w;
	logic signed [SUM_W-1:0] p_w;
	logic signed [SUM_W-1:0] y_w;

	qxm_pkg::motors_t motors_next;
	qxm_pkg::motors_t motors_q;
	logic             done_q;

	function automatic logic [qxm_pkg::MOTOR_W-1:0] clamp_motor(
		input logic signed [SUM_W-1:0] sum
	);
		logic signed [SUM_W-1:0]   lo;
		logic signed [SUM_W-1:0]   hi;
		logic signed [SUM_W-1:0]   c;
		logic [qxm_pkg::MOTOR_W-1:0] whole;
		lo = SUM_W'(qxm_pkg::MOTOR_MIN) <<< qxm_pkg::FRAC_BITS;
		hi = SUM_W'(qxm_pkg::MOTOR_MAX) <<< qxm_pkg::FRAC_BITS;
		priority if (sum >= hi) begin
			c = hi;
		end else if (sum < lo) begin
			c = lo;
		end else begin
			c = sum;
		end
		whole = c[qxm_pkg::FRAC_BITS +: qxm_pkg::MOTOR_W];
		return whole - qxm_pkg::MOTOR_W'(qxm_pkg::MOTOR_OFFSET);
	endfunction

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_trim_q <= '0;
			roll_trim_q     <= '0;
			pitch_trim_q    <= '0;
			yaw_trim_q      <= '0;
			roll_gain_q     <= '0;
			pitch_gain_q    <= '0;
			yaw_gain_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qxm_pkg::REG_THROTTLE_TRIM: begin
					throttle_trim_q <= cfg_data[qxm_pkg::TRIM_W-1:0];
				end
				qxm_pkg::REG_ROLL_TRIM: begin
					roll_trim_q <= cfg_data[qxm_pkg::TRIM_W-1:0];
				end
				qxm_pkg::REG_PITCH_TRIM: begin
					pitch_trim_q <= cfg_data[qxm_pkg::TRIM_W-1:0];
				end
				qxm_pkg::REG_YAW_TRIM: begin
					yaw_trim_q <= cfg_data[qxm_pkg::TRIM_W-1:0];
				end
				qxm_pkg::REG_ROLL_GAIN: begin
					roll_gain_q <= cfg_data[qxm_pkg::GAIN_W-1:0];
				end
				qxm_pkg::REG_PITCH_GAIN: begin
					pitch_gain_q <= cfg_data[qxm_pkg::GAIN_W-1:0];
				end
				qxm_pkg::REG_YAW_GAIN: begin
					yaw_gain_q <= cfg_data[qxm_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sample_s1 <= sample;
		end
	end

	qxm_axis u_roll (
		.pulse (sample_s1.roll_pulse),
		.trim  (roll_trim_q),
		.gain  (roll_gain_q),
		.gyro  (sample_s1.gyro_roll),
		.axis  (roll_axis)
	);

	qxm_axis u_pitch (
		.pulse (sample_s1.pitch_pulse),
		.trim  (pitch_trim_q),
		.gain  (pitch_gain_q),
		.gyro  (sample_s1.gyro_pitch),
		.axis  (pitch_axis)
	);

	qxm_axis u_yaw (
		.pulse (sample_s1.yaw_pulse),
		.trim  (yaw_trim_q),
		.gain  (yaw_gain_q),
		.gyro  (sample_s1.gyro_yaw),
		.axis  (yaw_axis)
	);

	assign thr_sum = signed'({2'b00, sample_s1.throttle_pulse}) + THR_C_W'(throttle_trim_q);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			thr_s2   <= {thr_sum, {qxm_pkg::FRAC_BITS{1'b0}}};
			roll_s2  <= roll_axis;
			pitch_s2 <= pitch_axis;
			yaw_s2   <= yaw_axis;
		end
	end

	assign t_w = SUM_W'(thr_s2);
	assign r_w = SUM_W'(roll_s2);
	assign p_w = SUM_W'(pitch_s2);
	assign y_w = SUM_W'(yaw_s2);

	always_comb begin
		motors_next.motor_front_right = clamp_motor(t_w - r_w - p_w + y_w);
		motors_next.motor_back_right  = clamp_motor(t_w - r_w + p_w - y_w);
		motors_next.motor_back_left   = clamp_motor(t_w + r_w + p_w + y_w);
		motors_next.motor_front_left  = clamp_motor(t_w + r_w - p_w - y_w);
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			motors_q <= motors_next;
		end
	end

	assign motors = motors_q;
	assign done   = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/qxm_axis.sv -----
`default_nettype none

module qxm_axis (
	input  wire logic        [qxm_pkg::PULSE_W-1:0] pulse,
	input  wire logic signed [qxm_pkg::TRIM_W-1:0]  trim,
	input  wire logic signed [qxm_pkg::GAIN_W-1:0]  gain,
	input  wire logic signed [qxm_pkg::GYRO_W-1:0]  gyro,
	output      logic signed [qxm_pkg::AXIS_W-1:0]  axis
);

	localparam int PROD_W = qxm_pkg::GAIN_W + qxm_pkg::GYRO_W;
	localparam int CENT_W = qxm_pkg::PULSE_W + 2;

	logic signed [CENT_W-1:0]                     centred;
	logic signed [CENT_W+qxm_pkg::FRAC_BITS-1:0]  base_q8;
	logic signed [PROD_W-1:0]                     prod;
	logic signed [PROD_W-qxm_pkg::FRAC_BITS-1:0]  damp_q8;

	assign centred = signed'({2'b00, pulse}) - CENT_W'(qxm_pkg::PULSE_CENTRE)
		+ CENT_W'(trim);
	assign base_q8 = {centred, {qxm_pkg::FRAC_BITS{1'b0}}};

	// The product carries 16 fraction bits; dropping the low 8 floors it to Q.8.
	assign prod    = PROD_W'(gain) * PROD_W'(gyro);
	assign damp_q8 = $signed(prod[PROD_W-1:qxm_pkg::FRAC_BITS]);

	assign axis = qxm_pkg::AXIS_W'(base_q8) - qxm_pkg::AXIS_W'(damp_q8);

endmodule

`default_nettype wire

// ----- verif/mixer_checker.sv -----
`timescale 1ns / 100ps

module mixer_checker
	import qxm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic                   busy,
	input  wire sample_t                sample,
	input  wire logic                   done,
	input  wire motors_t                motors,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output int                          mismatches,
	output int                          outstanding
);

	logic signed [TRIM_W-1:0] thr_trim;
	logic signed [TRIM_W-1:0] roll_trim;
	logic signed [TRIM_W-1:0] pitch_trim;
	logic signed [TRIM_W-1:0] yaw_trim;
	logic signed [GAIN_W-1:0] roll_gain;
	logic signed [GAIN_W-1:0] pitch_gain;
	logic signed [GAIN_W-1:0] yaw_gain;
	motors_t expected_motors [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// The damping product keeps 16 fraction bits; the arithmetic shift floors it to 8.
	function automatic longint axis_q8(input logic [PULSE_W-1:0] pulse,
			input logic signed [TRIM_W-1:0] trim, input logic signed [GAIN_W-1:0] gain,
			input logic signed [GYRO_W-1:0] gyro);
		longint damping;
		damping = (longint'(gain) * longint'(gyro)) >>> FRAC_BITS;
		return ((longint'(pulse) - PULSE_CENTRE + longint'(trim)) <<< FRAC_BITS) - damping;
	endfunction

	function automatic logic [MOTOR_W-1:0] motor_pulse(input longint sum_q8);
		longint clamped;
		clamped = sum_q8;
		if (clamped >= (longint'(MOTOR_MAX) <<< FRAC_BITS)) begin
			clamped = longint'(MOTOR_MAX) <<< FRAC_BITS;
		end else if (clamped < (longint'(MOTOR_MIN) <<< FRAC_BITS)) begin
			clamped = longint'(MOTOR_MIN) <<< FRAC_BITS;
		end
		return MOTOR_W'((clamped >>> FRAC_BITS) - MOTOR_OFFSET);
	endfunction

	function automatic motors_t mix_motors(input sample_t s);
		longint t;
		longint r;
		longint p;
		longint y;
		motors_t m;
		t = (longint'(s.throttle_pulse) + longint'(thr_trim)) <<< FRAC_BITS;
		r = axis_q8(s.roll_pulse, roll_trim, roll_gain, s.gyro_roll);
		p = axis_q8(s.pitch_pulse, pitch_trim, pitch_gain, s.gyro_pitch);
		y = axis_q8(s.yaw_pulse, yaw_trim, yaw_gain, s.gyro_yaw);
		m.motor_front_right = motor_pulse(t - r - p + y);
		m.motor_back_right  = motor_pulse(t - r + p - y);
		m.motor_back_left   = motor_pulse(t + r + p + y);
		m.motor_front_left  = motor_pulse(t + r - p - y);
		return m;
	endfunction

	task automatic check_field(input string name, input logic [MOTOR_W-1:0] want,
			input logic [MOTOR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		motors_t want;
		if (!arst_n) begin
			thr_trim <= '0;
			roll_trim <= '0;
			pitch_trim <= '0;
			yaw_trim <= '0;
			roll_gain <= '0;
			pitch_gain <= '0;
			yaw_gain <= '0;
			expected_motors.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THROTTLE_TRIM: thr_trim <= cfg_data[TRIM_W-1:0];
					REG_ROLL_TRIM: roll_trim <= cfg_data[TRIM_W-1:0];
					REG_PITCH_TRIM: pitch_trim <= cfg_data[TRIM_W-1:0];
					REG_YAW_TRIM: yaw_trim <= cfg_data[TRIM_W-1:0];
					REG_ROLL_GAIN: roll_gain <= cfg_data[GAIN_W-1:0];
					REG_PITCH_GAIN: pitch_gain <= cfg_data[GAIN_W-1:0];
					REG_YAW_GAIN: yaw_gain <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_motors.size() == 0) begin
					$error("motor result arrived with no item outstanding");
					mismatches++;
				end else begin
					want = expected_motors.pop_front();
					check_field("motor_front_right", want.motor_front_right,
						motors.motor_front_right);
					check_field("motor_back_right", want.motor_back_right,
						motors.motor_back_right);
					check_field("motor_back_left", want.motor_back_left,
						motors.motor_back_left);
					check_field("motor_front_left", want.motor_front_left,
						motors.motor_front_left);
				end
			end
			if (start && !busy) begin
				expected_motors.push_back(mix_motors(sample));
			end
			outstanding = expected_motors.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	import qxm_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
	localparam int NUM_REGS = 7;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sample_t sample;
	logic done;
	motors_t motors;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int mismatches;
	int outstanding;
	int stall_cycles = 0;
	bit gaps_on = 1'b1;

	quad_x_damped_motor_mixer uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.motors(motors),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mixer_checker motor_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.motors(motors),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic sample_t make_sample(input int thr, input int roll, input int pitch,
			input int yaw, input int g_roll, input int g_pitch, input int g_yaw);
		sample_t s;
		s.throttle_pulse = PULSE_W'(thr);
		s.roll_pulse = PULSE_W'(roll);
		s.pitch_pulse = PULSE_W'(pitch);
		s.yaw_pulse = PULSE_W'(yaw);
		s.gyro_roll = GYRO_W'(g_roll);
		s.gyro_pitch = GYRO_W'(g_pitch);
		s.gyro_yaw = GYRO_W'(g_yaw);
		return s;
	endfunction

	// Most items are plausible stick positions with modest rates; the rest are raw noise.
	function automatic sample_t rand_sample();
		sample_t s;
		if ($urandom_range(99) < 80) begin
			s.throttle_pulse = PULSE_W'($urandom_range(2050, 850));
			s.roll_pulse = PULSE_W'($urandom_range(2000, 1000));
			s.pitch_pulse = PULSE_W'($urandom_range(2000, 1000));
			s.yaw_pulse = PULSE_W'($urandom_range(2000, 1000));
			s.gyro_roll = GYRO_W'($urandom_range(8192) - 4096);
			s.gyro_pitch = GYRO_W'($urandom_range(8192) - 4096);
			s.gyro_yaw = GYRO_W'($urandom_range(8192) - 4096);
		end else begin
			s = sample_t'({$urandom, $urandom, $urandom});
		end
		return s;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_trim();
		logic [TRIM_W-1:0] t;
		case ($urandom_range(7))
			0: t = 10'h1FF;
			1: t = 10'h200;
			2, 3: t = TRIM_W'($urandom);
			default: t = TRIM_W'($urandom_range(200) - 100);
		endcase
		return {(CFG_DATA_W - TRIM_W)'($urandom), t};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_gain();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return CFG_DATA_W'($urandom);
			default: return CFG_DATA_W'($urandom_range(1536) - 768);
		endcase
	endfunction

	task automatic idle_gap();
		int n;
		int r;
		n = 0;
		r = $urandom_range(99);
		if (gaps_on) begin
			if (r >= 93) begin
				n = $urandom_range(40, 8);
			end else if (r >= 65) begin
				n = $urandom_range(3, 1);
			end
		end
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_item(input sample_t s);
		bit taken;
		idle_gap();
		start <= 1'b1;
		sample <= s;
		do begin
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] thr_trim,
			input logic [CFG_DATA_W-1:0] roll_trim, input logic [CFG_DATA_W-1:0] pitch_trim,
			input logic [CFG_DATA_W-1:0] yaw_trim, input logic [CFG_DATA_W-1:0] roll_gain,
			input logic [CFG_DATA_W-1:0] pitch_gain, input logic [CFG_DATA_W-1:0] yaw_gain,
			input bit spare);
		logic [CFG_DATA_W-1:0] vals [NUM_REGS];
		vals[REG_THROTTLE_TRIM] = thr_trim;
		vals[REG_ROLL_TRIM] = roll_trim;
		vals[REG_PITCH_TRIM] = pitch_trim;
		vals[REG_YAW_TRIM] = yaw_trim;
		vals[REG_ROLL_GAIN] = roll_gain;
		vals[REG_PITCH_GAIN] = pitch_gain;
		vals[REG_YAW_GAIN] = yaw_gain;
		drain();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data <= vals[i];
			@(negedge clk);
		end
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= CFG_DATA_W'($urandom);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration: clamp edges and pulses outside the stick range.
		send_item(make_sample(0, 0, 0, 0, 0, 0, 0));
		send_item(make_sample(4095, 4095, 4095, 4095, 32767, 32767, 32767));
		send_item(make_sample(1000, 1500, 1500, 1500, 0, 0, 0));
		send_item(make_sample(1900, 1500, 1500, 1500, 0, 0, 0));
		send_item(make_sample(1901, 1500, 1500, 1500, 0, 0, 0));
		send_item(make_sample(899, 1500, 1500, 1500, 0, 0, 0));
		send_item(make_sample(1500, 1600, 1450, 1520, -32768, -32768, -32768));

		// Tiny gains expose flooring of negative products and of fractional sums.
		configure(16'(0), 16'(0), 16'(0), 16'(0), 16'(1), 16'(-1), 16'h0180, 1'b1);
		send_item(make_sample(1200, 1500, 1500, 1500, -1, 0, 0));
		send_item(make_sample(1200, 1500, 1500, 1500, 1, 1, -3));
		send_item(make_sample(1300, 1510, 1490, 1500, -255, 255, 255));
		send_item(make_sample(1500, 1500, 1500, 1500, 32767, -32768, 32767));

		configure(16'(511), 16'(-512), 16'(511), 16'(-512), 16'h7FFF, 16'h8000, 16'h7FFF,
			1'b0);
		send_item(make_sample(1000, 1500, 1500, 1500, 0, 0, 0));
		send_item(make_sample(1000, 1500, 1500, 1500, -32768, -32768, -32768));
		send_item(make_sample(0, 0, 0, 0, 32767, 32767, 32767));
		send_item(make_sample(4095, 4095, 4095, 4095, -1, -1, -1));

		configure(16'(-512), 16'(511), 16'(-512), 16'(511), 16'h8000, 16'h7FFF, 16'h8000,
			1'b1);
		send_item(make_sample(2000, 1500, 1500, 1500, 0, 0, 0));
		send_item(make_sample(1900, 1000, 2000, 1000, 1, -1, 1));
		send_item(make_sample(2411, 989, 2011, 989, 0, 0, 0));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			gaps_on = (ph % 3 != 1);
			configure(rand_trim(), rand_trim(), rand_trim(), rand_trim(), rand_gain(),
				rand_gain(), rand_gain(), $urandom_range(3) == 0);
			repeat (ITEMS_PER_PHASE) send_item(rand_sample());
		end

		drain();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/qxm_pkg.sv
hw/rtl/qxm_axis.sv
hw/rtl/quad_x_damped_motor_mixer.sv
verif/mixer_checker.sv
verif/testbench.sv
